// ===== hw/rtl/json_string_escape_writer_macros.svh =====
// ----------------------------------------------------------------------------
// JSON string escape writer assertion macros
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPE_WRITER_MACROS_SVH
`define JSON_STRING_ESCAPE_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSEW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("JSEW same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSEW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("JSEW next-cycle check failed");

`endif

// ===== hw/rtl/jsew_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string escape writer package
// Types, codes and character constants shared by the front, queue and back.
// ----------------------------------------------------------------------------
package jsew_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_RAW  = 2'd0;
    localparam logic [1:0] OP_ESC  = 2'd1;
    localparam logic [1:0] OP_MISS = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Character constants.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration register.
    localparam int          PADDR_W     = 3;
    localparam logic [0:0]  REG_CAP     = 1'b0;
    localparam logic [15:0] CAP_RESET   = 16'd1024;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Expansion sequencer steps.
    localparam int          STEP_W    = 3;
    localparam logic [2:0]  STEP_0    = 3'd0;
    localparam logic [2:0]  STEP_1    = 3'd1;
    localparam logic [2:0]  STEP_2    = 3'd2;
    localparam logic [2:0]  STEP_3    = 3'd3;
    localparam logic [2:0]  STEP_4    = 3'd4;
    localparam logic [2:0]  STEP_5    = 3'd5;

    // Expansion kinds decided by the front.
    typedef enum logic [1:0] {
        K_RAW  = 2'd0,
        K_ESC2 = 2'd1,
        K_ESCU = 2'd2,
        K_MISS = 2'd3
    } t_kind;

    // One queued work descriptor: kind and its data byte.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_desc;

    // Front to queue write side.
    typedef struct packed {
        logic  push;
        t_desc desc;
    } t_qwr;

    // Queue status and head as seen by the back.
    typedef struct packed {
        logic  empty;
        logic  full;
        t_desc head;
    } t_qrd;

    // Writer state exported for checking.
    typedef struct packed {
        logic [15:0] fill;
        logic        failed;
    } t_wstat;

    // Lower-case hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = 8'h57 + {4'd0, nib};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/jsew_front.sv =====
// ----------------------------------------------------------------------------
// JSON string escape writer front end
// Accepts input beats and classifies each one into an expansion descriptor.
// ----------------------------------------------------------------------------
module jsew_front (
    input  logic              i_valid,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_text_byte,
    input  logic              i_q_full,
    output logic              o_ready,
    output jsew_pkg::t_qwr    o_qwr
);
    import jsew_pkg::*;

    logic [7:0] second;
    t_desc      desc;

    // Second character of the short escapes; zero when there is none.
    always_comb begin
        unique case (i_text_byte)
            CH_QUOTE: second = CH_QUOTE;
            CH_BSL:   second = CH_BSL;
            CH_BS:    second = CH_B;
            CH_FF:    second = CH_F;
            CH_LF:    second = CH_N;
            CH_CR:    second = CH_R;
            CH_TAB:   second = CH_T;
            default:  second = 8'h00;
        endcase
    end

    // Pick the expansion for this beat.
    always_comb begin
        desc.kind = K_RAW;
        desc.data = i_text_byte;
        unique case (i_opcode)
            OP_RAW: begin
                desc.kind = K_RAW;
            end
            OP_ESC: begin
                if (second != 8'h00) begin
                    desc.kind = K_ESC2;
                    desc.data = second;
                end else if (i_text_byte < CH_SPACE) begin
                    desc.kind = K_ESCU;
                end else begin
                    desc.kind = K_RAW;
                end
            end
            OP_MISS: begin
                desc.kind = K_MISS;
                desc.data = 8'h00;
            end
            default: begin
                desc.kind = K_RAW;
            end
        endcase
    end

    // An unused opcode is taken and dropped without a queue entry.
    assign o_ready    = !i_q_full;
    assign o_qwr.push = i_valid && !i_q_full && (i_opcode != OP_NONE);
    assign o_qwr.desc = desc;

endmodule

// ===== hw/rtl/jsew_queue.sv =====
// ----------------------------------------------------------------------------
// JSON string escape writer descriptor queue
// Small register queue that decouples classification from byte emission.
// ----------------------------------------------------------------------------
module jsew_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jsew_pkg::t_qwr    i_qwr,
    input  logic              i_pop,
    output jsew_pkg::t_qrd    o_qrd
);
    import jsew_pkg::*;

    t_desc              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  n_wr;
    logic [QPTR_W-1:0]  n_rd;
    logic [QCNT_W-1:0]  n_cnt;

    // Pointer and count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_qwr.push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        priority if (i_qwr.push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_qwr.push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_qwr.push) begin
            r_mem[r_wr] <= i_qwr.desc;
        end
    end

    assign o_qrd.empty = (r_cnt == '0);
    assign o_qrd.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_qrd.head  = r_mem[r_rd];

endmodule

// ===== hw/rtl/jsew_back.sv =====
// ----------------------------------------------------------------------------
// JSON string escape writer back end
// Steps through each descriptor one output byte per beat, tracks the fill
// length and the sticky failure flag, and holds the result in an output
// register.
// ----------------------------------------------------------------------------
module jsew_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_capacity,
    input  jsew_pkg::t_qrd    i_qrd,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic [15:0]       o_position,
    output logic              o_written,
    output logic              o_failed,
    output logic              o_last,
    output jsew_pkg::t_wstat  o_stat
);
    import jsew_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [15:0]       r_fill;
    logic [15:0]       n_fill;
    logic              r_fail;
    logic              n_fail;
    logic              r_valid;
    logic              n_valid;
    logic [7:0]        r_byte;
    logic [15:0]       r_pos;
    logic              r_written;
    logic              r_failed;
    logic              r_last;

    logic              load;
    logic              fire;
    logic [7:0]        cur_byte;
    logic              cur_last;
    logic              room;
    logic              wr_now;

    // Output register takes a new beat when empty or being drained.
    assign load = !r_valid || i_ready;
    assign fire = load && !i_qrd.empty;

    // Byte and end of expansion for the current step.
    always_comb begin
        cur_byte = i_qrd.head.data;
        cur_last = 1'b1;
        unique case (i_qrd.head.kind)
            K_RAW, K_MISS: begin
                cur_byte = i_qrd.head.data;
                cur_last = 1'b1;
            end
            K_ESC2: begin
                cur_byte = (r_step == STEP_0) ? CH_BSL : i_qrd.head.data;
                cur_last = (r_step == STEP_1);
            end
            K_ESCU: begin
                cur_last = (r_step == STEP_5);
                unique case (r_step)
                    STEP_0:  cur_byte = CH_BSL;
                    STEP_1:  cur_byte = CH_U;
                    STEP_2:  cur_byte = CH_ZERO;
                    STEP_3:  cur_byte = CH_ZERO;
                    STEP_4:  cur_byte = hex_digit(i_qrd.head.data[7:4]);
                    default: cur_byte = hex_digit(i_qrd.head.data[3:0]);
                endcase
            end
            default: begin
                cur_byte = i_qrd.head.data;
                cur_last = 1'b1;
            end
        endcase
    end

    // Bound test: a byte fits while fill + 1 stays below the capacity.
    assign room   = ({1'b0, r_fill} + 17'd1) < {1'b0, i_capacity};
    assign wr_now = (i_qrd.head.kind != K_MISS) && !r_fail && room;

    // Writer state and step sequencing.
    always_comb begin
        n_step  = r_step;
        n_fill  = r_fill;
        n_fail  = r_fail;
        n_valid = r_valid;
        if (load) begin
            n_valid = !i_qrd.empty;
        end
        if (fire) begin
            n_step = cur_last ? STEP_0 : (r_step + 1'b1);
            if (i_qrd.head.kind == K_MISS) begin
                n_fail = 1'b1;
            end else if (!r_fail) begin
                if (room) begin
                    n_fill = r_fill + 16'd1;
                end else begin
                    n_fail = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_0;
            r_fill  <= '0;
            r_fail  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_fill  <= n_fill;
            r_fail  <= n_fail;
            r_valid <= n_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte    <= cur_byte;
            r_pos     <= r_fill;
            r_written <= wr_now;
            r_failed  <= n_fail;
            r_last    <= cur_last;
        end
    end

    assign o_pop         = fire && cur_last;
    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_position    = r_pos;
    assign o_written     = r_written;
    assign o_failed      = r_failed;
    assign o_last        = r_last;
    assign o_stat.fill   = r_fill;
    assign o_stat.failed = r_fail;

endmodule

// ===== hw/rtl/json_string_escape_writer.sv =====
// ----------------------------------------------------------------------------
// JSON string escape writer
// Appends raw or JSON-escaped text bytes to a bounded buffer and reports
// each output byte with its position, store status and sticky failure.
// ----------------------------------------------------------------------------
//  Channel  Dir  Fields (low bit up)
//  s_axis   in   tdata: text_byte[7:0]; tuser: opcode[1:0]
//  m_axis   out  tdata: out_byte[7:0], position[23:8], written[24],
//                failed[25], zero[31:26]; tlast: last
//  apb      in   buffer_capacity at byte address 0, 16 bits
//
// One output byte leaves per cycle while the output is not stalled; a raw
// byte gives one output byte, a short escape two and a \u00xx escape six, set by the back end sequencer.
// A four-entry descriptor queue lets input beats keep arriving while an
// expansion runs; the input stalls only when the queue is full.
// The output register accepts a new beat in the cycle it is drained.
// Reset clears the fill length, failure flag and queue, and loads a
// capacity of 1024.
// ----------------------------------------------------------------------------
`include "json_string_escape_writer_macros.svh"

module json_string_escape_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // text_byte[7:0]
    input  logic [1:0]                    s_axis_tuser,  // opcode[1:0]
    // Output stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_byte[7:0], position[23:8], written[24], failed[25], zero[31:26]
    output logic [31:0]                   m_axis_tdata,
    output logic                          m_axis_tlast,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jsew_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import jsew_pkg::*;

    logic [15:0] r_cap;
    t_qwr        qwr;
    t_qrd        qrd;
    logic        pop;
    t_wstat      stat;
    logic [7:0]  out_byte;
    logic [15:0] position;
    logic        written;
    logic        failed;

    // Configuration register.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAP)) begin
            r_cap <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAP) ? {16'd0, r_cap} : 32'd0;

    // Front end: accept and classify.
    jsew_front u_front (
        .i_valid     (s_axis_tvalid),
        .i_opcode    (s_axis_tuser),
        .i_text_byte (s_axis_tdata),
        .i_q_full    (qrd.full),
        .o_ready     (s_axis_tready),
        .o_qwr       (qwr)
    );

    // Descriptor queue.
    jsew_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_pop   (pop),
        .o_qrd   (qrd)
    );

    // Back end: emit bytes and track the buffer.
    jsew_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_cap),
        .i_qrd      (qrd),
        .o_pop      (pop),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_out_byte (out_byte),
        .o_position (position),
        .o_written  (written),
        .o_failed   (failed),
        .o_last     (m_axis_tlast),
        .o_stat     (stat)
    );

    assign m_axis_tdata = {6'd0, failed, written, position, out_byte};

    // A stored byte never reports failure.
    `JSEW_ASSERT_IMP(a_written_not_failed, i_clk, i_rst_n, m_axis_tvalid && written, !failed)

    // A stored byte lies inside the buffer bound.
    `JSEW_ASSERT_IMP(a_written_in_bound, i_clk, i_rst_n, m_axis_tvalid && written, ({1'b0, position} + 17'd1) < {1'b0, r_cap})

    // The failure flag never clears once set.
    `JSEW_ASSERT_NEXT(a_fail_sticky, i_clk, i_rst_n, stat.failed, stat.failed)

endmodule
